>>> rtl/color_pixel_threshold_scale_assert.svh
// ----------------------------------------------------------------------------
// color_pixel_threshold_scale_assert.svh
// Assertion macros shared by the pixel threshold and scale block.
// ----------------------------------------------------------------------------
`ifndef COLOR_PIXEL_THRESHOLD_SCALE_ASSERT_SVH
`define COLOR_PIXEL_THRESHOLD_SCALE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CPTS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cpts assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CPTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cpts assertion failed");

`endif

>>> rtl/cpts_pkg.sv
// ----------------------------------------------------------------------------
// cpts_pkg
// Constants and types of the pixel threshold and scale block.
// ----------------------------------------------------------------------------
package cpts_pkg;

  localparam int CHANNEL_BITS = 8;
  localparam int NUM_CHANNELS = 3;
  // One quotient bit is settled per divider cell.
  localparam int QUOT_STEPS   = CHANNEL_BITS;

  typedef logic [CHANNEL_BITS-1:0] chan_t;

  localparam chan_t CHAN_MAX     = {CHANNEL_BITS{1'b1}};
  localparam chan_t THRESH_RESET = chan_t'(110);

  // Per-channel state of the long division c*255 / m.
  typedef struct packed {
    chan_t rem;   // partial remainder, always below the divisor
    chan_t num;   // numerator bits still to be shifted in, MSB first
    chan_t quot;  // quotient bits settled so far
  } div_lane_t;

  typedef struct packed {
    logic                             keep;  // pixel keeps color (else black)
    chan_t                            m;     // channel maximum, the divisor
    div_lane_t [NUM_CHANNELS-1:0]     lane;
  } div_word_t;

endpackage

>>> rtl/cpts_in_if.sv
// ----------------------------------------------------------------------------
// cpts_in_if
// Input pixel channel: valid/ready handshake and three color channels.
// ----------------------------------------------------------------------------
interface cpts_in_if;
  import cpts_pkg::*;

  logic  valid;
  logic  ready;
  chan_t chan_a_in;
  chan_t chan_b_in;
  chan_t chan_c_in;

  modport source (output valid, output chan_a_in, output chan_b_in, output chan_c_in,
                  input ready);
  modport sink   (input valid, input chan_a_in, input chan_b_in, input chan_c_in,
                  output ready);
endinterface

>>> rtl/cpts_out_if.sv
// ----------------------------------------------------------------------------
// cpts_out_if
// Result pixel channel: valid/ready handshake and three color channels.
// ----------------------------------------------------------------------------
interface cpts_out_if;
  import cpts_pkg::*;

  logic  valid;
  logic  ready;
  chan_t chan_a_out;
  chan_t chan_b_out;
  chan_t chan_c_out;

  modport source (output valid, output chan_a_out, output chan_b_out, output chan_c_out,
                  input ready);
  modport sink   (input valid, input chan_a_out, input chan_b_out, input chan_c_out,
                  output ready);
endinterface

>>> rtl/cpts_front.sv
// ----------------------------------------------------------------------------
// cpts_front
// Input stage: channel maximum, color decision and division setup.
// ----------------------------------------------------------------------------
module cpts_front (
  input  logic                clk,
  input  logic                rst_n,
  input  cpts_pkg::chan_t     threshold,
  cpts_in_if.sink             pix,
  output logic                out_valid,
  input  logic                out_ready,
  output cpts_pkg::div_word_t out_word
);
  import cpts_pkg::*;

  logic                          valid_r;
  div_word_t                     word_r;
  div_word_t                     word_nxt;
  chan_t                         max_ab;
  chan_t                         max_abc;
  logic [CHANNEL_BITS+1:0]       sum;
  logic [CHANNEL_BITS+3:0]       sum_x5;
  logic [CHANNEL_BITS+3:0]       max_x12;
  logic                          white;
  logic                          load;
  logic [2*CHANNEL_BITS-1:0]     numer [NUM_CHANNELS];
  chan_t                         chans [NUM_CHANNELS];

  assign load      = !valid_r || out_ready;
  assign pix.ready = load;

  always_comb begin
    chans[0] = pix.chan_a_in;
    chans[1] = pix.chan_b_in;
    chans[2] = pix.chan_c_in;
    max_ab   = (chans[1] > chans[0]) ? chans[1] : chans[0];
    max_abc  = (chans[2] > max_ab) ? chans[2] : max_ab;
    sum      = {2'b00, chans[0]} + {2'b00, chans[1]} + {2'b00, chans[2]};
    sum_x5   = {2'b00, sum} + {sum, 2'b00};
    max_x12  = {1'b0, max_abc, 3'b000} + {2'b00, max_abc, 2'b00};
    white    = (chans[0] == CHAN_MAX) && (chans[1] == CHAN_MAX) && (chans[2] == CHAN_MAX);

    word_nxt.keep = white || ((max_abc > threshold) && (sum_x5 < max_x12));
    word_nxt.m    = max_abc;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      // c*255 as c*256 - c. Its upper half is below m because c <= m.
      numer[i] = {chans[i], {CHANNEL_BITS{1'b0}}} - {{CHANNEL_BITS{1'b0}}, chans[i]};
      word_nxt.lane[i].rem  = numer[i][2*CHANNEL_BITS-1:CHANNEL_BITS];
      word_nxt.lane[i].num  = numer[i][CHANNEL_BITS-1:0];
      word_nxt.lane[i].quot = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= pix.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && pix.valid) begin
      word_r <= word_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_word  = word_r;
endmodule

>>> rtl/cpts_div_cell.sv
// ----------------------------------------------------------------------------
// cpts_div_cell
// One restoring division step for all three channels, with its own register.
// ----------------------------------------------------------------------------
module cpts_div_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  cpts_pkg::div_word_t in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output cpts_pkg::div_word_t out_word
);
  import cpts_pkg::*;

  logic                  valid_r;
  div_word_t             word_r;
  div_word_t             word_nxt;
  logic [CHANNEL_BITS:0] rem_sh [NUM_CHANNELS];
  logic [CHANNEL_BITS:0] rem_sub [NUM_CHANNELS];
  logic                  fits [NUM_CHANNELS];
  logic                  load;

  assign load     = !valid_r || out_ready;
  assign in_ready = load;

  always_comb begin
    word_nxt = in_word;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      rem_sh[i]  = {in_word.lane[i].rem, in_word.lane[i].num[CHANNEL_BITS-1]};
      rem_sub[i] = rem_sh[i] - {1'b0, in_word.m};
      fits[i]    = rem_sh[i] >= {1'b0, in_word.m};
      // Either way the new remainder is below m, so it fits a channel width.
      word_nxt.lane[i].rem  = fits[i] ? rem_sub[i][CHANNEL_BITS-1:0]
                                      : rem_sh[i][CHANNEL_BITS-1:0];
      word_nxt.lane[i].num  = {in_word.lane[i].num[CHANNEL_BITS-2:0], 1'b0};
      word_nxt.lane[i].quot = {in_word.lane[i].quot[CHANNEL_BITS-2:0], fits[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      word_r <= word_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_word  = word_r;
endmodule

>>> rtl/cpts_round.sv
// ----------------------------------------------------------------------------
// cpts_round
// Output stage: round half to even, blacken rejected pixels, output register.
// ----------------------------------------------------------------------------
module cpts_round (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  cpts_pkg::div_word_t in_word,
  cpts_out_if.source          pix
);
  import cpts_pkg::*;

  logic                  valid_r;
  chan_t                 res_r [NUM_CHANNELS];
  chan_t                 res_nxt [NUM_CHANNELS];
  logic [CHANNEL_BITS:0] two_rem [NUM_CHANNELS];
  logic [CHANNEL_BITS:0] bumped [NUM_CHANNELS];
  logic                  up [NUM_CHANNELS];
  logic                  load;

  assign load     = !valid_r || pix.ready;
  assign in_ready = load;

  always_comb begin
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      two_rem[i] = {in_word.lane[i].rem, 1'b0};
      up[i]      = (two_rem[i] > {1'b0, in_word.m}) ||
                   ((two_rem[i] == {1'b0, in_word.m}) && in_word.lane[i].quot[0]);
      bumped[i]  = {1'b0, in_word.lane[i].quot} + {{CHANNEL_BITS{1'b0}}, up[i]};
      if (!in_word.keep) begin
        res_nxt[i] = '0;
      end else if (bumped[i][CHANNEL_BITS]) begin
        res_nxt[i] = CHAN_MAX;
      end else begin
        res_nxt[i] = bumped[i][CHANNEL_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      res_r <= res_nxt;
    end
  end

  assign pix.valid      = valid_r;
  assign pix.chan_a_out = res_r[0];
  assign pix.chan_b_out = res_r[1];
  assign pix.chan_c_out = res_r[2];
endmodule

>>> rtl/color_pixel_threshold_scale.sv
// ----------------------------------------------------------------------------
// color_pixel_threshold_scale
// Color pixel threshold and rescale to full range.
// ----------------------------------------------------------------------------
// One pixel transfer is accepted per clock cycle while the output side is not
// stalled. Each pixel passes through one input stage that finds the channel
// maximum and makes the color decision, a chain of eight division cells that
// each settle one quotient bit of c*255/max for all three channels, and one
// rounding stage that holds the output register. Every stage has its own
// valid bit and accepts new data whenever it is empty or its successor takes
// its content, so gaps in the stream are absorbed while the output waits.
// A pure white pixel comes out white, a pixel whose maximum is not above the
// threshold or whose mean is at least 80% of the maximum comes out black.
// ----------------------------------------------------------------------------
module color_pixel_threshold_scale (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_wr_en,
  input  cpts_pkg::chan_t cfg_wr_data,
  cpts_in_if.sink         in_pix,
  cpts_out_if.source      out_pix
);
  import cpts_pkg::*;

  `include "color_pixel_threshold_scale_assert.svh"

  chan_t     threshold_r;
  logic      vld [QUOT_STEPS+1];
  logic      rdy [QUOT_STEPS+1];
  div_word_t word [QUOT_STEPS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THRESH_RESET;
    end else if (cfg_wr_en) begin
      threshold_r <= cfg_wr_data;
    end
  end

  cpts_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .threshold (threshold_r),
    .pix       (in_pix),
    .out_valid (vld[0]),
    .out_ready (rdy[0]),
    .out_word  (word[0])
  );

  for (genvar g = 0; g < QUOT_STEPS; g++) begin : g_cell
    cpts_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (vld[g]),
      .in_ready  (rdy[g]),
      .in_word   (word[g]),
      .out_valid (vld[g+1]),
      .out_ready (rdy[g+1]),
      .out_word  (word[g+1])
    );
  end

  cpts_round u_round (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (vld[QUOT_STEPS]),
    .in_ready (rdy[QUOT_STEPS]),
    .in_word  (word[QUOT_STEPS]),
    .pix      (out_pix)
  );

  // A kept pixel always has one channel equal to the maximum, which scales to full range.
  `CPTS_ASSERT_NOW(a_out_full_or_black, clk, rst_n, out_pix.valid,
    (out_pix.chan_a_out == CHAN_MAX) || (out_pix.chan_b_out == CHAN_MAX) ||
    (out_pix.chan_c_out == CHAN_MAX) ||
    ((out_pix.chan_a_out == '0) && (out_pix.chan_b_out == '0) && (out_pix.chan_c_out == '0)))
  // An empty input stage must take the next transfer.
  `CPTS_ASSERT_NOW(a_in_ready_when_empty, clk, rst_n, !vld[0], in_pix.ready)
  // No result appears without an item leaving the last division cell.
  `CPTS_ASSERT_NEXT(a_no_invented_result, clk, rst_n,
    out_pix.valid && out_pix.ready && !vld[QUOT_STEPS], !out_pix.valid)
endmodule
